/* src/nbss_pkg.sv */
// shared constants, types and fixed-point helpers for the n-body skew step block
`timescale 1ns / 1ps
package nbss_pkg;

    localparam int NUM_PARTICLES = 1024;
    localparam int IDX_W         = $clog2(NUM_PARTICLES);
    localparam int CNT_W         = $clog2(NUM_PARTICLES + 1);
    localparam int FRAC_BITS     = 16;
    localparam int VAL_W         = 32;
    localparam int PROD_W        = 66;
    localparam int SUM_W         = 68;
    localparam int N2_W          = SUM_W - FRAC_BITS;
    localparam int QUO_W         = 31;
    localparam int QCNT_W        = $clog2(QUO_W);
    localparam int PADDR_W       = 4;

    localparam logic [VAL_W-1:0] ONE_FX = VAL_W'(1) << FRAC_BITS;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_FRAME = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] REG_ACTIVE = 2'd0;
    localparam logic [1:0] REG_RADIUS = 2'd1;
    localparam logic [1:0] REG_LIGHT  = 2'd2;

    typedef logic [2:0][VAL_W-1:0] t_vec3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_WR,
        ST_RD_OUT,
        ST_ADV_RD,
        ST_ADV_LAT,
        ST_ADV_G1,
        ST_ADV_G2,
        ST_ADV_G3,
        ST_ADV_G4,
        ST_ADV_G5,
        ST_ADV_WR,
        ST_ROW_RD,
        ST_ROW_LAT,
        ST_PR_RD,
        ST_PR_LAT,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_N2,
        ST_TM_MUL,
        ST_TM_CHK,
        ST_TM_DIV,
        ST_TM_ACC,
        ST_PR_WR,
        ST_ROW_WR,
        ST_FR_DONE
    } t_state;

    function automatic logic [VAL_W-1:0] sat32(input logic [SUM_W-1:0] x);
        logic [VAL_W-1:0] r;
        if (x[SUM_W-1:VAL_W-1] == '0 || x[SUM_W-1:VAL_W-1] == '1) begin
            r = x[VAL_W-1:0];
        end else if (x[SUM_W-1]) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] ext32(input logic [VAL_W-1:0] v);
        return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

    function automatic logic [VAL_W:0] mag32(input logic [VAL_W-1:0] v);
        logic [VAL_W:0] r;
        r = v[VAL_W-1] ? ({1'b0, ~v} + (VAL_W+1)'(1)) : {1'b0, v};
        return r;
    endfunction

    function automatic logic [VAL_W:0] mag33(input logic [VAL_W:0] v);
        logic [VAL_W:0] r;
        r = v[VAL_W] ? (~v + (VAL_W+1)'(1)) : v;
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] floor_sat(input logic [PROD_W-1:0] mag,
                                                    input logic neg);
        logic [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] sh;
        v  = {{(SUM_W-PROD_W){1'b0}}, mag};
        if (neg) begin
            v = ~v + SUM_W'(1);
        end
        sh = $signed(v) >>> FRAC_BITS;
        return sat32(sh);
    endfunction

endpackage

/* src/nbody_skew_step_top.sv */
// particle store and frame engine with a shared multiplier and a bit-serial divider
`timescale 1ns / 1ps
// A request is taken when i_start is high and o_busy is low; its result shows on the
// result ports for exactly one cycle, marked by o_done, and cannot be held off.
// A load passes through a multiply state and a write state, a read through one read-out
// state; a rejected or unknown request and a frame with no active particles are answered
// straight from the idle state. In a frame each particle is advanced through the shared
// multiplier, and each pair needs up to six divisions of one quotient bit per cycle in
// the divider. Particle data lives in single-port-read memories; entries never loaded
// read back as undefined.
module nbody_skew_step_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_req_type,
    input  logic [nbss_pkg::IDX_W-1:0]        i_index,
    input  logic [nbss_pkg::VAL_W-1:0]        i_mass,
    input  logic signed [nbss_pkg::VAL_W-1:0] i_in_pos_x,
    input  logic signed [nbss_pkg::VAL_W-1:0] i_in_pos_y,
    input  logic signed [nbss_pkg::VAL_W-1:0] i_in_pos_z,
    input  logic signed [nbss_pkg::VAL_W-1:0] i_in_vel_x,
    input  logic signed [nbss_pkg::VAL_W-1:0] i_in_vel_y,
    input  logic signed [nbss_pkg::VAL_W-1:0] i_in_vel_z,
    output logic                              o_done,
    output logic                              o_status,
    output logic signed [nbss_pkg::VAL_W-1:0] o_out_pos_x,
    output logic signed [nbss_pkg::VAL_W-1:0] o_out_pos_y,
    output logic signed [nbss_pkg::VAL_W-1:0] o_out_pos_z,
    output logic signed [nbss_pkg::VAL_W-1:0] o_out_vel_x,
    output logic signed [nbss_pkg::VAL_W-1:0] o_out_vel_y,
    output logic signed [nbss_pkg::VAL_W-1:0] o_out_vel_z,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nbss_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int VW = nbss_pkg::VAL_W;
    localparam int IW = nbss_pkg::IDX_W;
    localparam int CW = nbss_pkg::CNT_W;
    localparam int PW = nbss_pkg::PROD_W;
    localparam int SW = nbss_pkg::SUM_W;
    localparam int NW = nbss_pkg::N2_W;
    localparam int QW = nbss_pkg::QUO_W;
    localparam int KW = nbss_pkg::QCNT_W;

    // memories
    nbss_pkg::t_vec3 mem_pos  [nbss_pkg::NUM_PARTICLES];
    nbss_pkg::t_vec3 mem_vel  [nbss_pkg::NUM_PARTICLES];
    nbss_pkg::t_vec3 mem_skew [nbss_pkg::NUM_PARTICLES];
    logic [VW-1:0]   mem_rad  [nbss_pkg::NUM_PARTICLES];

    nbss_pkg::t_vec3 r_pos_rd, r_vel_rd, r_skew_rd;
    logic [VW-1:0]   r_rad_rd;

    logic            pos_we, vel_we, skew_we, rad_we;
    logic [IW-1:0]   wr_addr, rd_addr;
    nbss_pkg::t_vec3 pos_wd, vel_wd, skew_wd;
    logic [VW-1:0]   rad_wd;

    // control
    nbss_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_i, n_i, r_j, n_j;
    logic [1:0]       r_ax, n_ax;
    logic             r_side, n_side;
    logic [KW-1:0]    r_cnt, n_cnt;
    logic             r_o_done, n_o_done;
    logic [CW-1:0]    r_active_count;
    logic [VW-1:0]    r_radius_factor, r_light_step;

    // datapath
    nbss_pkg::t_vec3  r_pa, n_pa, r_va, n_va, r_sa, n_sa, r_sb, n_sb;
    logic [2:0][VW:0] r_d, n_d;
    logic [VW-1:0]    r_rs_a, n_rs_a, r_rs_b, n_rs_b, r_t, n_t;
    logic [SW-1:0]    r_sum, n_sum;
    logic [NW-1:0]    r_n2, n_n2, r_rem, n_rem;
    logic [QW-1:0]    r_num_lo, n_num_lo, r_q, n_q;
    logic             r_sat, n_sat;
    logic [PW-1:0]    r_prod_mag;
    logic             r_prod_neg;
    logic [VW:0]      mul_a, mul_b;
    logic             mul_neg;

    nbss_pkg::t_vec3 r_ld_pos, n_ld_pos, r_ld_vel, n_ld_vel;
    logic [VW-1:0]   r_ld_mass, n_ld_mass;
    logic [IW-1:0]   r_ld_idx, n_ld_idx;

    logic            r_o_status, n_o_status;
    nbss_pkg::t_vec3 r_o_pos, n_o_pos, r_o_vel, n_o_vel;

    // helpers
    logic [CW-1:0]   act_n;
    logic            accept, in_range, cfg_wr;
    logic            adv_last, pr_last, row_last, n2_zero, div_last, chk_sat, trial_ge;
    logic [VW:0]     s_mag, f_mag, t_mag, d_mag;
    logic [VW+1:0]   f_val;
    logic [VW-1:0]   prod_fl, rad_sat;
    logic [PW-1:0]   rad_full;
    logic [NW:0]     trial;
    logic [VW+1:0]   term;

    assign act_n    = (r_active_count > CW'(nbss_pkg::NUM_PARTICLES)) ?
                      CW'(nbss_pkg::NUM_PARTICLES) : r_active_count;
    assign accept   = i_start && (r_state == nbss_pkg::ST_IDLE);
    assign in_range = CW'(i_index) < act_n;
    assign cfg_wr   = psel && penable && pwrite;

    assign adv_last = (r_i + CW'(1)) == act_n;
    assign pr_last  = (r_j + CW'(1)) == act_n;
    assign row_last = (r_i + CW'(2)) == act_n;
    assign n2_zero  = (r_sum[SW-1:nbss_pkg::FRAC_BITS] == '0);
    assign div_last = (r_cnt == KW'(QW - 1));
    assign chk_sat  = {{(NW-(PW-1-QW)){1'b0}}, r_prod_mag[PW-2:QW]} >= r_n2;

    assign s_mag    = nbss_pkg::mag32(r_sa[r_ax]);
    assign f_val    = {2'b00, nbss_pkg::ONE_FX} - {1'b0, s_mag};
    assign f_mag    = f_val[VW+1] ? 33'(~f_val + (VW+2)'(1)) : f_val[VW:0];
    assign t_mag    = nbss_pkg::mag32(r_t);
    assign d_mag    = nbss_pkg::mag33(r_d[r_ax]);
    assign prod_fl  = nbss_pkg::floor_sat(r_prod_mag, r_prod_neg);
    assign rad_full = r_prod_mag >> nbss_pkg::FRAC_BITS;
    assign rad_sat  = (rad_full[PW-1:VW] != '0) ? '1 : rad_full[VW-1:0];
    assign trial    = {r_rem, r_num_lo[QW-1]};
    assign trial_ge = trial >= {1'b0, r_n2};

    always_comb begin
        if (r_sat) begin
            term = r_d[r_ax][VW] ? {{2{1'b1}}, 1'b1, {(VW-1){1'b0}}}
                                 : {2'b00, 1'b0, {(VW-1){1'b1}}};
        end else if (r_d[r_ax][VW]) begin
            term = ~{3'b000, r_q} + (VW+2)'(1);
        end else begin
            term = {3'b000, r_q};
        end
    end

    assign o_busy      = (r_state != nbss_pkg::ST_IDLE);
    assign o_done      = r_o_done;
    assign o_status    = r_o_status;
    assign o_out_pos_x = r_o_pos[0];
    assign o_out_pos_y = r_o_pos[1];
    assign o_out_pos_z = r_o_pos[2];
    assign o_out_vel_x = r_o_vel[0];
    assign o_out_vel_y = r_o_vel[1];
    assign o_out_vel_z = r_o_vel[2];
    assign pready      = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            nbss_pkg::REG_ACTIVE: prdata = 32'(r_active_count);
            nbss_pkg::REG_RADIUS: prdata = r_radius_factor;
            nbss_pkg::REG_LIGHT:  prdata = r_light_step;
            default:              prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nbss_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_req_type)
                        nbss_pkg::REQ_LOAD:  n_state = in_range ? nbss_pkg::ST_LD_MUL
                                                               : nbss_pkg::ST_IDLE;
                        nbss_pkg::REQ_READ:  n_state = in_range ? nbss_pkg::ST_RD_OUT
                                                               : nbss_pkg::ST_IDLE;
                        nbss_pkg::REQ_FRAME: n_state = (act_n != '0) ? nbss_pkg::ST_ADV_RD
                                                                     : nbss_pkg::ST_IDLE;
                        default:             n_state = nbss_pkg::ST_IDLE;
                    endcase
                end
            end
            nbss_pkg::ST_LD_MUL:  n_state = nbss_pkg::ST_LD_WR;
            nbss_pkg::ST_LD_WR:   n_state = nbss_pkg::ST_IDLE;
            nbss_pkg::ST_RD_OUT:  n_state = nbss_pkg::ST_IDLE;
            nbss_pkg::ST_ADV_RD:  n_state = nbss_pkg::ST_ADV_LAT;
            nbss_pkg::ST_ADV_LAT: n_state = nbss_pkg::ST_ADV_G1;
            nbss_pkg::ST_ADV_G1:  n_state = nbss_pkg::ST_ADV_G2;
            nbss_pkg::ST_ADV_G2:  n_state = nbss_pkg::ST_ADV_G3;
            nbss_pkg::ST_ADV_G3:  n_state = nbss_pkg::ST_ADV_G4;
            nbss_pkg::ST_ADV_G4:  n_state = nbss_pkg::ST_ADV_G5;
            nbss_pkg::ST_ADV_G5:  n_state = (r_ax == 2'd2) ? nbss_pkg::ST_ADV_WR
                                                          : nbss_pkg::ST_ADV_G1;
            nbss_pkg::ST_ADV_WR: begin
                if (!adv_last) begin
                    n_state = nbss_pkg::ST_ADV_RD;
                end else if (act_n < CW'(2)) begin
                    n_state = nbss_pkg::ST_FR_DONE;
                end else begin
                    n_state = nbss_pkg::ST_ROW_RD;
                end
            end
            nbss_pkg::ST_ROW_RD:  n_state = nbss_pkg::ST_ROW_LAT;
            nbss_pkg::ST_ROW_LAT: n_state = nbss_pkg::ST_PR_RD;
            nbss_pkg::ST_PR_RD:   n_state = nbss_pkg::ST_PR_LAT;
            nbss_pkg::ST_PR_LAT:  n_state = nbss_pkg::ST_SQ_MUL;
            nbss_pkg::ST_SQ_MUL:  n_state = nbss_pkg::ST_SQ_ADD;
            nbss_pkg::ST_SQ_ADD:  n_state = (r_ax == 2'd2) ? nbss_pkg::ST_N2
                                                          : nbss_pkg::ST_SQ_MUL;
            nbss_pkg::ST_N2:      n_state = n2_zero ? nbss_pkg::ST_PR_WR
                                                    : nbss_pkg::ST_TM_MUL;
            nbss_pkg::ST_TM_MUL:  n_state = nbss_pkg::ST_TM_CHK;
            nbss_pkg::ST_TM_CHK:  n_state = chk_sat ? nbss_pkg::ST_TM_ACC
                                                    : nbss_pkg::ST_TM_DIV;
            nbss_pkg::ST_TM_DIV:  n_state = div_last ? nbss_pkg::ST_TM_ACC
                                                     : nbss_pkg::ST_TM_DIV;
            nbss_pkg::ST_TM_ACC:  n_state = (r_ax == 2'd2 && r_side) ? nbss_pkg::ST_PR_WR
                                                                     : nbss_pkg::ST_TM_MUL;
            nbss_pkg::ST_PR_WR:   n_state = pr_last ? nbss_pkg::ST_ROW_WR
                                                    : nbss_pkg::ST_PR_RD;
            nbss_pkg::ST_ROW_WR:  n_state = row_last ? nbss_pkg::ST_FR_DONE
                                                     : nbss_pkg::ST_ROW_RD;
            nbss_pkg::ST_FR_DONE: n_state = nbss_pkg::ST_IDLE;
            default:              n_state = nbss_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_i = r_i;           n_j = r_j;           n_ax = r_ax;
        n_side = r_side;     n_cnt = r_cnt;
        n_pa = r_pa;         n_va = r_va;         n_sa = r_sa;       n_sb = r_sb;
        n_d = r_d;           n_rs_a = r_rs_a;     n_rs_b = r_rs_b;   n_t = r_t;
        n_sum = r_sum;       n_n2 = r_n2;         n_rem = r_rem;
        n_num_lo = r_num_lo; n_q = r_q;           n_sat = r_sat;
        n_ld_pos = r_ld_pos; n_ld_vel = r_ld_vel; n_ld_mass = r_ld_mass;
        n_ld_idx = r_ld_idx;
        n_o_done = 1'b0;     n_o_status = 1'b0;   n_o_pos = '0;      n_o_vel = '0;
        mul_a = '0;          mul_b = '0;          mul_neg = 1'b0;
        pos_we = 1'b0;       vel_we = 1'b0;       skew_we = 1'b0;    rad_we = 1'b0;
        wr_addr = r_i[IW-1:0];
        rd_addr = r_i[IW-1:0];
        pos_wd = r_pa;       vel_wd = r_va;       skew_wd = r_sa;    rad_wd = rad_sat;

        unique case (r_state)
            nbss_pkg::ST_IDLE: begin
                rd_addr   = i_index;
                n_ld_pos  = {i_in_pos_z, i_in_pos_y, i_in_pos_x};
                n_ld_vel  = {i_in_vel_z, i_in_vel_y, i_in_vel_x};
                n_ld_mass = i_mass;
                n_ld_idx  = i_index;
                n_i       = '0;
                n_ax      = 2'd0;
                if (accept) begin
                    unique case (i_req_type)
                        nbss_pkg::REQ_LOAD, nbss_pkg::REQ_READ: begin
                            if (!in_range) begin
                                n_o_done   = 1'b1;
                                n_o_status = 1'b1;
                            end
                        end
                        nbss_pkg::REQ_FRAME: n_o_done = (act_n == '0);
                        default:             n_o_done = 1'b1;
                    endcase
                end
            end
            nbss_pkg::ST_LD_MUL: begin
                mul_a = {1'b0, r_radius_factor};
                mul_b = {1'b0, r_ld_mass};
            end
            nbss_pkg::ST_LD_WR: begin
                wr_addr  = r_ld_idx;
                pos_we   = 1'b1;
                vel_we   = 1'b1;
                skew_we  = 1'b1;
                rad_we   = 1'b1;
                pos_wd   = r_ld_pos;
                vel_wd   = r_ld_vel;
                skew_wd  = {nbss_pkg::ONE_FX, nbss_pkg::ONE_FX, nbss_pkg::ONE_FX};
                n_o_done = 1'b1;
            end
            nbss_pkg::ST_RD_OUT: begin
                n_o_done = 1'b1;
                n_o_pos  = r_pos_rd;
                n_o_vel  = r_vel_rd;
            end
            nbss_pkg::ST_ADV_RD: begin
                rd_addr = r_i[IW-1:0];
            end
            nbss_pkg::ST_ADV_LAT: begin
                n_pa = r_pos_rd;
                n_va = r_vel_rd;
                n_sa = r_skew_rd;
                n_ax = 2'd0;
            end
            nbss_pkg::ST_ADV_G1: begin
                mul_a   = s_mag;
                mul_b   = f_mag;
                mul_neg = r_sa[r_ax][VW-1] ^ f_val[VW+1];
            end
            nbss_pkg::ST_ADV_G2: begin
                n_t = prod_fl;
            end
            nbss_pkg::ST_ADV_G3: begin
                mul_a   = t_mag;
                mul_b   = {1'b0, r_light_step};
                mul_neg = r_t[VW-1];
            end
            nbss_pkg::ST_ADV_G4: begin
                n_va[r_ax] = nbss_pkg::sat32(nbss_pkg::ext32(r_va[r_ax])
                                             + nbss_pkg::ext32(prod_fl));
            end
            nbss_pkg::ST_ADV_G5: begin
                n_pa[r_ax] = nbss_pkg::sat32(nbss_pkg::ext32(r_pa[r_ax])
                                             + nbss_pkg::ext32(r_va[r_ax]));
                n_ax = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
            end
            nbss_pkg::ST_ADV_WR: begin
                wr_addr = r_i[IW-1:0];
                pos_we  = 1'b1;
                vel_we  = 1'b1;
                skew_we = 1'b1;
                skew_wd = {nbss_pkg::ONE_FX, nbss_pkg::ONE_FX, nbss_pkg::ONE_FX};
                n_i     = adv_last ? '0 : r_i + CW'(1);
            end
            nbss_pkg::ST_ROW_RD: begin
                rd_addr = r_i[IW-1:0];
            end
            nbss_pkg::ST_ROW_LAT: begin
                n_pa   = r_pos_rd;
                n_sa   = r_skew_rd;
                n_rs_a = r_rad_rd;
                n_j    = r_i + CW'(1);
            end
            nbss_pkg::ST_PR_RD: begin
                rd_addr = r_j[IW-1:0];
            end
            nbss_pkg::ST_PR_LAT: begin
                n_sb   = r_skew_rd;
                n_rs_b = r_rad_rd;
                for (int k = 0; k < 3; k++) begin
                    n_d[k] = {r_pos_rd[k][VW-1], r_pos_rd[k]} - {r_pa[k][VW-1], r_pa[k]};
                end
                n_ax  = 2'd0;
                n_sum = '0;
            end
            nbss_pkg::ST_SQ_MUL: begin
                mul_a = d_mag;
                mul_b = d_mag;
            end
            nbss_pkg::ST_SQ_ADD: begin
                n_sum = r_sum + {{(SW-PW){1'b0}}, r_prod_mag};
                n_ax  = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
            end
            nbss_pkg::ST_N2: begin
                n_n2   = r_sum[SW-1:nbss_pkg::FRAC_BITS];
                n_ax   = 2'd0;
                n_side = 1'b0;
            end
            nbss_pkg::ST_TM_MUL: begin
                mul_a = {1'b0, (r_side ? r_rs_a : r_rs_b)};
                mul_b = d_mag;
            end
            nbss_pkg::ST_TM_CHK: begin
                n_sat    = chk_sat;
                n_rem    = {{(NW-(PW-1-QW)){1'b0}}, r_prod_mag[PW-2:QW]};
                n_num_lo = r_prod_mag[QW-1:0];
                n_q      = '0;
                n_cnt    = '0;
            end
            nbss_pkg::ST_TM_DIV: begin
                n_rem    = trial_ge ? NW'(trial - {1'b0, r_n2}) : trial[NW-1:0];
                n_q      = {r_q[QW-2:0], trial_ge};
                n_num_lo = {r_num_lo[QW-2:0], 1'b0};
                n_cnt    = r_cnt + KW'(1);
            end
            nbss_pkg::ST_TM_ACC: begin
                if (r_side) begin
                    n_sb[r_ax] = nbss_pkg::sat32(nbss_pkg::ext32(r_sb[r_ax])
                                 - {{(SW-VW-2){term[VW+1]}}, term});
                end else begin
                    n_sa[r_ax] = nbss_pkg::sat32(nbss_pkg::ext32(r_sa[r_ax])
                                 + {{(SW-VW-2){term[VW+1]}}, term});
                end
                if (r_ax == 2'd2) begin
                    n_ax   = 2'd0;
                    n_side = 1'b1;
                end else begin
                    n_ax = r_ax + 2'd1;
                end
            end
            nbss_pkg::ST_PR_WR: begin
                wr_addr = r_j[IW-1:0];
                skew_we = 1'b1;
                skew_wd = r_sb;
                n_j     = r_j + CW'(1);
            end
            nbss_pkg::ST_ROW_WR: begin
                wr_addr = r_i[IW-1:0];
                skew_we = 1'b1;
                skew_wd = r_sa;
                n_i     = r_i + CW'(1);
            end
            nbss_pkg::ST_FR_DONE: begin
                n_o_done = 1'b1;
            end
            default: begin
                n_o_done = 1'b0;
            end
        endcase
    end

    // memories, one read and one write port each
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            mem_pos[wr_addr] <= pos_wd;
        end
        if (vel_we) begin
            mem_vel[wr_addr] <= vel_wd;
        end
        if (skew_we) begin
            mem_skew[wr_addr] <= skew_wd;
        end
        if (rad_we) begin
            mem_rad[wr_addr] <= rad_wd;
        end
        r_pos_rd  <= mem_pos[rd_addr];
        r_vel_rd  <= mem_vel[rd_addr];
        r_skew_rd <= mem_skew[rd_addr];
        r_rad_rd  <= mem_rad[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= nbss_pkg::ST_IDLE;
            r_o_done        <= 1'b0;
            r_i             <= '0;
            r_j             <= '0;
            r_ax            <= 2'd0;
            r_side          <= 1'b0;
            r_cnt           <= '0;
            r_active_count  <= '0;
            r_radius_factor <= '0;
            r_light_step    <= nbss_pkg::ONE_FX;
        end else begin
            r_state  <= n_state;
            r_o_done <= n_o_done;
            r_i      <= n_i;
            r_j      <= n_j;
            r_ax     <= n_ax;
            r_side   <= n_side;
            r_cnt    <= n_cnt;
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    nbss_pkg::REG_ACTIVE: r_active_count  <= pwdata[CW-1:0];
                    nbss_pkg::REG_RADIUS: r_radius_factor <= pwdata;
                    nbss_pkg::REG_LIGHT:  r_light_step    <= pwdata;
                    default:              r_light_step    <= r_light_step;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa       <= n_pa;
        r_va       <= n_va;
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_d        <= n_d;
        r_rs_a     <= n_rs_a;
        r_rs_b     <= n_rs_b;
        r_t        <= n_t;
        r_sum      <= n_sum;
        r_n2       <= n_n2;
        r_rem      <= n_rem;
        r_num_lo   <= n_num_lo;
        r_q        <= n_q;
        r_sat      <= n_sat;
        r_prod_mag <= mul_a * mul_b;
        r_prod_neg <= mul_neg;
        r_ld_pos   <= n_ld_pos;
        r_ld_vel   <= n_ld_vel;
        r_ld_mass  <= n_ld_mass;
        r_ld_idx   <= n_ld_idx;
        r_o_status <= n_o_status;
        r_o_pos    <= n_o_pos;
        r_o_vel    <= n_o_vel;
    end

endmodule

/* verif/nbody_skew_step_checker.sv */
// request monitor, particle-state predictor and result comparator for the n-body skew step
`timescale 1ns / 1ps
module nbody_skew_step_checker
    import nbss_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [1:0]              i_req_type,
    input  logic [IDX_W-1:0]        i_index,
    input  logic [VAL_W-1:0]        i_mass,
    input  logic [VAL_W-1:0]        i_in_pos_x,
    input  logic [VAL_W-1:0]        i_in_pos_y,
    input  logic [VAL_W-1:0]        i_in_pos_z,
    input  logic [VAL_W-1:0]        i_in_vel_x,
    input  logic [VAL_W-1:0]        i_in_vel_y,
    input  logic [VAL_W-1:0]        i_in_vel_z,
    input  logic                    i_done,
    input  logic                    i_status,
    input  logic [VAL_W-1:0]        i_out_pos_x,
    input  logic [VAL_W-1:0]        i_out_pos_y,
    input  logic [VAL_W-1:0]        i_out_pos_z,
    input  logic [VAL_W-1:0]        i_out_vel_x,
    input  logic [VAL_W-1:0]        i_out_vel_y,
    input  logic [VAL_W-1:0]        i_out_vel_z,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [31:0]             pwdata,
    input  logic                    pready,
    output int                      o_errors,
    output int                      o_pending
);

    typedef struct packed {
        logic              status;
        logic [5:0][31:0]  data;
    } t_particle_rsp;

    t_particle_rsp rsp_q[$];

    int pos_mem [3][NUM_PARTICLES];
    int vel_mem [3][NUM_PARTICLES];
    int skew_mem[3][NUM_PARTICLES];
    logic [31:0] radius_mem[NUM_PARTICLES];

    logic [10:0] cfg_active;
    logic [31:0] cfg_radius;
    logic [31:0] cfg_light;

    function automatic int sat_s32(longint x);
        if (x > longint'(32'sh7fffffff)) return 32'sh7fffffff;
        if (x < -longint'(64'sh80000000)) return 32'sh80000000;
        return int'(x);
    endfunction

    function automatic int skew_gain(int s);
        longint a, m, t;
        a = s;
        m = (a < 0) ? -a : a;
        t = sat_s32((a * (longint'(ONE_FX) - m)) >>> FRAC_BITS);
        return sat_s32((t * longint'({32'b0, cfg_light})) >>> FRAC_BITS);
    endfunction

    function automatic longint pull_term(logic [31:0] rs, longint d, logic [51:0] n2);
        logic [67:0] m, q;
        m = (d < 0) ? 68'(-d) : 68'(d);
        q = (68'(rs) * m) / 68'(n2);
        if (d < 0) return (q > 68'h80000000) ? -longint'(64'h80000000) : -longint'(q);
        return (q > 68'h7fffffff) ? longint'(32'h7fffffff) : longint'(q);
    endfunction

    function automatic int particles_in_play();
        return (cfg_active > NUM_PARTICLES) ? NUM_PARTICLES : int'(cfg_active);
    endfunction

    task automatic advance_frame();
        int n;
        longint d[3];
        logic [67:0] sum;
        logic [51:0] n2;
        n = particles_in_play();
        for (int i = 0; i < n; i++) begin
            for (int a = 0; a < 3; a++) begin
                vel_mem[a][i] = sat_s32(longint'(vel_mem[a][i]) + skew_gain(skew_mem[a][i]));
                pos_mem[a][i] = sat_s32(longint'(pos_mem[a][i]) + vel_mem[a][i]);
                skew_mem[a][i] = int'(ONE_FX);
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                sum = '0;
                for (int a = 0; a < 3; a++) begin
                    d[a] = longint'(pos_mem[a][j]) - longint'(pos_mem[a][i]);
                    sum += ((d[a] < 0) ? 68'(-d[a]) : 68'(d[a]))
                         * ((d[a] < 0) ? 68'(-d[a]) : 68'(d[a]));
                end
                n2 = sum[67:FRAC_BITS];
                if (n2 != 0) begin
                    for (int a = 0; a < 3; a++) begin
                        skew_mem[a][i] = sat_s32(longint'(skew_mem[a][i])
                                         + pull_term(radius_mem[j], d[a], n2));
                        skew_mem[a][j] = sat_s32(longint'(skew_mem[a][j])
                                         - pull_term(radius_mem[i], d[a], n2));
                    end
                end
            end
        end
    endtask

    task automatic predict_request();
        t_particle_rsp r;
        logic [63:0] rad;
        int idx;
        r = '0;
        idx = i_index;
        if (i_req_type == REQ_LOAD || i_req_type == REQ_READ) begin
            if (idx >= particles_in_play()) begin
                r.status = 1'b1;
            end else if (i_req_type == REQ_LOAD) begin
                rad = (64'(cfg_radius) * 64'(i_mass)) >> FRAC_BITS;
                pos_mem[0][idx] = i_in_pos_x;
                pos_mem[1][idx] = i_in_pos_y;
                pos_mem[2][idx] = i_in_pos_z;
                vel_mem[0][idx] = i_in_vel_x;
                vel_mem[1][idx] = i_in_vel_y;
                vel_mem[2][idx] = i_in_vel_z;
                radius_mem[idx] = (rad > 64'hffffffff) ? 32'hffffffff : rad[31:0];
                for (int a = 0; a < 3; a++) skew_mem[a][idx] = int'(ONE_FX);
            end else begin
                for (int a = 0; a < 3; a++) begin
                    r.data[5-a] = pos_mem[a][idx];
                    r.data[2-a] = vel_mem[a][idx];
                end
            end
        end else if (i_req_type == REQ_FRAME) begin
            advance_frame();
        end
        rsp_q.push_back(r);
    endtask

    task automatic compare_result();
        t_particle_rsp got, want;
        got.status = i_status;
        got.data = {i_out_pos_x, i_out_pos_y, i_out_pos_z, i_out_vel_x, i_out_vel_y, i_out_vel_z};
        if (rsp_q.size() == 0) begin
            o_errors++;
            if (o_errors <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
            want = rsp_q.pop_front();
            if (got.status !== want.status || got.data !== want.data) begin
                o_errors++;
                if (o_errors <= 10) begin
                    $display("mismatch at %0t: status exp %0d got %0d", $realtime,
                             want.status, got.status);
                    $display("  exp pos %h %h %h vel %h %h %h", want.data[5], want.data[4],
                             want.data[3], want.data[2], want.data[1], want.data[0]);
                    $display("  got pos %h %h %h vel %h %h %h", got.data[5], got.data[4],
                             got.data[3], got.data[2], got.data[1], got.data[0]);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors = 0;
            rsp_q.delete();
            cfg_active = '0;
            cfg_radius = '0;
            cfg_light = ONE_FX;
            for (int i = 0; i < NUM_PARTICLES; i++) begin
                radius_mem[i] = '0;
                for (int a = 0; a < 3; a++) begin
                    pos_mem[a][i] = 0;
                    vel_mem[a][i] = 0;
                    skew_mem[a][i] = 0;
                end
            end
        end else begin
            if (i_done) compare_result();
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ACTIVE: cfg_active = pwdata[10:0];
                    REG_RADIUS: cfg_radius = pwdata;
                    REG_LIGHT:  cfg_light  = pwdata;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) predict_request();
        end
        o_pending = rsp_q.size();
    end

endmodule

/* verif/nbody_skew_step_top_tb.sv */
// stimulus, clock, reset and verdict for the n-body skew step block
`timescale 1ns / 1ps
module nbody_skew_step_top_tb;
    import nbss_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int STALL_LIMIT = 400000;

    logic i_clk, i_rst_n, i_start, o_busy;
    logic [1:0] i_req_type;
    logic [IDX_W-1:0] i_index;
    logic [VAL_W-1:0] i_mass;
    logic signed [VAL_W-1:0] i_in_pos_x, i_in_pos_y, i_in_pos_z;
    logic signed [VAL_W-1:0] i_in_vel_x, i_in_vel_y, i_in_vel_z;
    logic o_done, o_status;
    logic signed [VAL_W-1:0] o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic signed [VAL_W-1:0] o_out_vel_x, o_out_vel_y, o_out_vel_z;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    int errors, pending, stall_cycles;
    int n_load, n_read, n_frame, n_other, n_phase;
    bit loaded[NUM_PARTICLES];
    int loaded_list[$];

    nbody_skew_step_top uut (.*);

    nbody_skew_step_checker chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_req_type, .i_index, .i_mass,
        .i_in_pos_x, .i_in_pos_y, .i_in_pos_z, .i_in_vel_x, .i_in_vel_y, .i_in_vel_z,
        .i_done(o_done), .i_status(o_status), .i_out_pos_x(o_out_pos_x),
        .i_out_pos_y(o_out_pos_y), .i_out_pos_z(o_out_pos_z), .i_out_vel_x(o_out_vel_x),
        .i_out_vel_y(o_out_vel_y), .i_out_vel_z(o_out_vel_z), .psel, .penable, .pwrite,
        .paddr, .pwdata, .pready, .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // no-progress watchdog
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (psel && penable) || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(0, 32'h00100000)) - 32'h00080000;
            3: return 32'($urandom_range(0, 32'h04000000)) - 32'h02000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_idle();
        i_start = 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] reg_idx, logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {reg_idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // call at a falling edge; returns at a falling edge
    task automatic send_request(logic [1:0] req, int idx, logic [31:0] mass,
                                logic [31:0] v[6], int gap, int active);
        i_req_type = req;
        i_index = idx[IDX_W-1:0];
        i_mass = mass;
        {i_in_pos_x, i_in_pos_y, i_in_pos_z} = {v[0], v[1], v[2]};
        {i_in_vel_x, i_in_vel_y, i_in_vel_z} = {v[3], v[4], v[5]};
        i_start = 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (req == REQ_LOAD && idx < active && !loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
        case (req)
            REQ_LOAD:  n_load++;
            REQ_READ:  n_read++;
            REQ_FRAME: n_frame++;
            default:   n_other++;
        endcase
        @(negedge i_clk);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic load_random(int idx, int gap, int active);
        logic [31:0] v[6];
        foreach (v[k]) v[k] = pick_value();
        send_request(REQ_LOAD, idx, (($urandom_range(0, 3) == 0) ? 32'hffffffff : $urandom),
                     v, gap, active);
    endtask

    task automatic simple_request(logic [1:0] req, int idx, int gap, int active);
        logic [31:0] v[6];
        foreach (v[k]) v[k] = $urandom;
        send_request(req, idx, $urandom, v, gap, active);
    endtask

    initial begin
        logic [31:0] v[6];
        int active, eff, gap, pick, idx, n_items;
        logic [31:0] rf, ls;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req_type = REQ_LOAD;
        i_index = '0;
        i_mass = '0;
        {i_in_pos_x, i_in_pos_y, i_in_pos_z, i_in_vel_x, i_in_vel_y, i_in_vel_z} = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        n_load = 0; n_read = 0; n_frame = 0; n_other = 0; n_phase = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty set, single particle, extremes, coincident pair
        simple_request(REQ_FRAME, 0, 1, 0);
        simple_request(REQ_READ, 0, 0, 0);
        simple_request(REQ_LOAD, 1023, 2, 0);
        simple_request(REQ_NONE, 1023, 1, 0);
        wait_idle();
        reg_write(REG_ACTIVE, 32'd1);
        active = 1;
        load_random(0, 0, active);
        simple_request(REQ_FRAME, 0, 0, active);
        simple_request(REQ_READ, 0, 3, active);
        wait_idle();
        reg_write(REG_ACTIVE, 32'd4);
        reg_write(REG_RADIUS, 32'hffffffff);
        reg_write(REG_LIGHT, 32'hffffffff);
        active = 4;
        v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h0};
        send_request(REQ_LOAD, 0, 32'hffffffff, v, 0, active);
        v = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0};
        send_request(REQ_LOAD, 1, 32'h0, v, 1, active);
        v = '{32'h00010000, 32'h00020000, 32'hfffd0000, 32'h0, 32'h0, 32'h0};
        send_request(REQ_LOAD, 2, 32'h00010000, v, 0, active);
        send_request(REQ_LOAD, 3, 32'h00030000, v, 0, active);
        simple_request(REQ_FRAME, 0, 2, active);
        simple_request(REQ_FRAME, 0, 0, active);
        for (int k = 0; k < 4; k++) simple_request(REQ_READ, k, k, active);
        simple_request(REQ_LOAD, 4, 0, active);
        simple_request(REQ_READ, 1023, 1, active);

        // random phases, each under its own register settings
        for (int ph = 0; ph < 16; ph++) begin
            wait_idle();
            n_phase++;
            case (ph)
                3:  active = 8;
                5:  active = 1024;
                9:  active = 2047;
                12: active = 0;
                default: active = $urandom_range(2, 6);
            endcase
            eff = (active > NUM_PARTICLES) ? NUM_PARTICLES : active;
            case (ph % 3)
                0: rf = $urandom_range(0, 32'h00100000);
                1: rf = (ph == 4) ? 32'h0 : 32'hffffffff;
                default: rf = $urandom;
            endcase
            case (ph % 4)
                0: ls = ONE_FX;
                1: ls = 32'h0;
                2: ls = 32'hffffffff;
                default: ls = $urandom;
            endcase
            reg_write(REG_ACTIVE, active);
            reg_write(REG_RADIUS, rf);
            reg_write(REG_LIGHT, ls);
            if (eff <= 8) begin
                for (int k = 0; k < eff; k++) load_random(k, $urandom_range(0, 2), active);
            end else begin
                load_random(1023, 0, active);
                simple_request(REQ_READ, 1023, 0, active);
            end
            n_items = (ph == 3) ? 25 : 40;
            for (int it = 0; it < n_items; it++) begin
                gap = (ph % 4 == 1) ? 0 : $urandom_range(0, 16);
                pick = $urandom_range(0, 99);
                if (pick < 40 && eff > 0) begin
                    load_random($urandom_range(0, eff - 1), gap, active);
                end else if (pick < 75 && loaded_list.size() > 0) begin
                    do idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                    while (idx >= eff && eff > 0);
                    if (eff == 0) idx = $urandom_range(0, 1023);
                    simple_request(REQ_READ, idx, gap, active);
                end else if (pick < 88 && eff <= 8) begin
                    simple_request(REQ_FRAME, $urandom_range(0, 1023), gap, active);
                end else if (pick < 94 || eff >= NUM_PARTICLES) begin
                    simple_request(REQ_NONE, $urandom_range(0, 1023), gap, active);
                end else begin
                    simple_request(($urandom_range(0, 1) != 0) ? REQ_LOAD : REQ_READ,
                                   $urandom_range(eff, 1023), gap, active);
                end
            end
        end

        i_start = 1'b0;
        fork
            begin
                wait (pending == 0);
                repeat (50) @(posedge i_clk);
            end
            begin
                repeat (STALL_LIMIT) @(posedge i_clk);
            end
        join_any
        $display("covered %0d loads, %0d reads, %0d frames, %0d other requests", n_load,
                 n_read, n_frame, n_other);
        $display("over %0d register settings, with empty, single and full particle sets",
                 n_phase + 3);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
src/nbss_pkg.sv
src/nbody_skew_step_top.sv
verif/nbody_skew_step_checker.sv
verif/nbody_skew_step_top_tb.sv
